[rtl/core/hpv_pkg.sv]
// hpv_pkg: shared constants, result codes and types for the histogram
// peak and valley finder; no dependencies
`timescale 1ns / 1ps

package hpv_pkg;

    // histogram geometry
    localparam int NUM_BINS   = 256;
    localparam int IDX_BITS   = $clog2(NUM_BINS);
    localparam int COUNT_BITS = 32;
    localparam int THR_BITS   = 32;
    localparam int TOTAL_BITS = IDX_BITS + 1;

    // result queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FILL_BITS  = PTR_BITS + 1;
    localparam int MAX_PUSH   = 3;

    // result kinds
    typedef enum logic [1:0] {
        KIND_VALLEY = 2'd0,
        KIND_PEAK   = 2'd1,
        KIND_OK     = 2'd2,
        KIND_FAIL   = 2'd3
    } t_kind;

    // one queued result
    typedef struct packed {
        logic [IDX_BITS-1:0]   idx;
        t_kind                 kind;
        logic [TOTAL_BITS-1:0] total;
        logic                  last;
    } t_result;

endpackage

[rtl/core/hpv_if.sv]
// hpv_if: valid/ready channels of the histogram peak and valley finder
// depends on hpv_pkg
`timescale 1ns / 1ps

// bin input channel
interface hpv_bin_if import hpv_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] bin_count;
    logic        final_bin;

    modport source (output valid, output bin_count, output final_bin, input ready);
    modport sink   (input valid, input bin_count, input final_bin, output ready);
endinterface

// result output channel
interface hpv_result_if import hpv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IDX_BITS-1:0]   extremum_index;
    logic [1:0]            result_kind;
    logic [TOTAL_BITS-1:0] extrema_found;
    logic                  end_of_run;

    modport source (output valid, output extremum_index, output result_kind,
                    output extrema_found, output end_of_run, input ready);
    modport sink   (input valid, input extremum_index, input result_kind,
                    input extrema_found, input end_of_run, output ready);
endinterface

// threshold write channel
interface hpv_cfg_if import hpv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [THR_BITS-1:0] hysteresis_threshold;

    modport source (output valid, output hysteresis_threshold, input ready);
    modport sink   (input valid, input hysteresis_threshold, output ready);
endinterface

[rtl/core/histogram_peak_valley_finder.sv]
// histogram_peak_valley_finder: top level, hysteresis peak/valley search
// depends on hpv_pkg and the channels in hpv_if
`timescale 1ns / 1ps

// Bins stream in from index zero, one bin per transaction, and the block
// answers with alternating valley and peak indices, then one done result
// (success or failure) after the bin marked final or the bin at index
// NUM_BINS-1. A bin is accepted every cycle as long as the eight-entry
// result queue has room for three results. The bin is registered in the
// input register and evaluated from there, and its results are written into
// the queue, from which they are offered. Results leave at one per cycle
// through the output channel while the sink is ready, so a sink that stalls,
// or a run of bins that each yield several results, throttles input through
// the queue fill. The threshold must be written only while the block is
// idle; the block itself does not enforce this. Its channel is always ready.
module histogram_peak_valley_finder
    import hpv_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    hpv_bin_if.sink             i_bin,
    hpv_cfg_if.sink             i_cfg,
    hpv_result_if.source        o_result
);

    // configuration
    logic [THR_BITS-1:0]   r_threshold;

    // input register
    logic                  r_in_valid;
    logic [COUNT_BITS-1:0] r_in_count;
    logic                  r_in_final;

    // run state
    logic [IDX_BITS-1:0]   r_bin_index;
    logic [COUNT_BITS-1:0] r_prev_count;
    logic                  r_rising;
    logic                  r_started;
    logic                  r_failed;
    logic [COUNT_BITS-1:0] r_peak_height;
    logic [IDX_BITS-1:0]   r_peak_pos;
    logic [COUNT_BITS-1:0] r_valley_height;
    logic [IDX_BITS-1:0]   r_valley_pos;
    logic [IDX_BITS-1:0]   r_last_pos;
    logic [TOTAL_BITS-1:0] r_total;

    logic [IDX_BITS-1:0]   n_bin_index;
    logic                  n_rising;
    logic                  n_started;
    logic                  n_failed;
    logic [COUNT_BITS-1:0] n_peak_height;
    logic [IDX_BITS-1:0]   n_peak_pos;
    logic [COUNT_BITS-1:0] n_valley_height;
    logic [IDX_BITS-1:0]   n_valley_pos;
    logic [IDX_BITS-1:0]   n_last_pos;
    logic [TOTAL_BITS-1:0] n_total;

    // result queue
    t_result               r_fifo [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [FILL_BITS-1:0]  r_fill;

    // step results
    logic                  w_proc;
    logic                  w_last;
    logic                  w_mid_v;
    t_result               w_mid;
    logic                  w_fin_v;
    t_result               w_fin;
    t_result               w_done;
    logic                  w_pop;
    logic [FILL_BITS-1:0]  w_push_n;
    logic [PTR_BITS-1:0]   w_fin_ptr;
    logic [PTR_BITS-1:0]   w_done_ptr;

    // handshakes
    assign w_proc        = r_in_valid && ((FILL_BITS'(FIFO_DEPTH) - r_fill) >=
                                          FILL_BITS'(MAX_PUSH));
    assign i_bin.ready   = !r_in_valid || w_proc;
    assign i_cfg.ready   = 1'b1;
    assign w_pop         = o_result.valid && o_result.ready;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg.valid) begin
            r_threshold <= i_cfg.hysteresis_threshold;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_bin.ready) begin
            r_in_valid <= i_bin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bin.valid && i_bin.ready) begin
            r_in_count <= i_bin.bin_count[COUNT_BITS-1:0];
            r_in_final <= i_bin.final_bin;
        end
    end

    // one bin step: direction, hysteresis commits and run closing
    always_comb begin
        logic [IDX_BITS-1:0] i;
        logic [COUNT_BITS-1:0] c;
        i               = r_bin_index;
        c               = r_in_count;
        n_rising        = r_rising;
        n_started       = r_started;
        n_failed        = r_failed;
        n_peak_height   = r_peak_height;
        n_peak_pos      = r_peak_pos;
        n_valley_height = r_valley_height;
        n_valley_pos    = r_valley_pos;
        n_last_pos      = r_last_pos;
        n_total         = r_total;
        n_bin_index     = i + IDX_BITS'(1);
        w_mid_v         = 1'b0;
        w_mid           = '{idx: '0, kind: KIND_VALLEY, total: '0, last: 1'b0};
        w_fin_v         = 1'b0;
        w_fin           = '{idx: '0, kind: KIND_VALLEY, total: '0, last: 1'b0};
        w_done          = '{idx: '0, kind: KIND_OK, total: '0, last: 1'b1};
        w_last          = r_in_final || (i == IDX_BITS'(NUM_BINS - 1));

        if (i == '0) begin
            // bin zero above threshold fails the run
            if (c > r_threshold) begin
                n_failed = 1'b1;
            end
        end else if (!r_failed) begin
            // first valley: the bin right before the first non-zero bin past bin zero
            if (!r_started && c != '0) begin
                n_started    = 1'b1;
                n_valley_pos = i - IDX_BITS'(1);
                n_total      = n_total + TOTAL_BITS'(1);
                n_last_pos   = i - IDX_BITS'(1);
                w_mid_v      = 1'b1;
                w_mid        = '{idx: i - IDX_BITS'(1), kind: KIND_VALLEY,
                                 total: n_total, last: 1'b0};
            end
            if (n_started) begin
                if (c > r_prev_count) begin
                    n_rising = 1'b1;
                end else if (c < r_prev_count) begin
                    n_rising = 1'b0;
                end
                if (n_rising) begin
                    // climbing away from the tentative valley
                    if (c > n_valley_height && (c - n_valley_height) > r_threshold) begin
                        if (n_total > TOTAL_BITS'(1) && n_valley_pos > n_last_pos) begin
                            n_total       = n_total + TOTAL_BITS'(1);
                            n_last_pos    = n_valley_pos;
                            w_mid_v       = 1'b1;
                            w_mid         = '{idx: n_valley_pos, kind: KIND_VALLEY,
                                              total: n_total, last: 1'b0};
                            n_peak_height = n_valley_height;
                        end
                        if (c > n_peak_height) begin
                            n_peak_height = c;
                            n_peak_pos    = i;
                        end
                    end
                end else begin
                    // falling away from the tentative peak
                    if (n_peak_height > c && (n_peak_height - c) > r_threshold) begin
                        if (n_peak_pos > n_last_pos) begin
                            n_total         = n_total + TOTAL_BITS'(1);
                            n_last_pos      = n_peak_pos;
                            w_mid_v         = 1'b1;
                            w_mid           = '{idx: n_peak_pos, kind: KIND_PEAK,
                                                total: n_total, last: 1'b0};
                            n_valley_height = n_peak_height;
                        end
                        if (c < n_valley_height) begin
                            n_valley_height = c;
                            n_valley_pos    = i;
                        end
                    end
                end
            end
        end

        // close the run: pending valley, then done
        if (w_last) begin
            if (n_failed) begin
                w_done = '{idx: '0, kind: KIND_FAIL, total: '0, last: 1'b1};
            end else begin
                if (n_started && n_valley_pos > n_last_pos) begin
                    n_total = n_total + TOTAL_BITS'(1);
                    w_fin_v = 1'b1;
                    w_fin   = '{idx: n_valley_pos, kind: KIND_VALLEY,
                                total: n_total, last: 1'b0};
                end
                w_done = '{idx: '0, kind: KIND_OK, total: n_total, last: 1'b1};
            end
            n_bin_index     = '0;
            n_rising        = 1'b1;
            n_started       = 1'b0;
            n_failed        = 1'b0;
            n_peak_height   = '0;
            n_peak_pos      = '0;
            n_valley_height = '0;
            n_valley_pos    = '0;
            n_last_pos      = '0;
            n_total         = '0;
        end
    end

    // run state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_index     <= '0;
            r_prev_count    <= '0;
            r_rising        <= 1'b1;
            r_started       <= 1'b0;
            r_failed        <= 1'b0;
            r_peak_height   <= '0;
            r_peak_pos      <= '0;
            r_valley_height <= '0;
            r_valley_pos    <= '0;
            r_last_pos      <= '0;
            r_total         <= '0;
        end else if (w_proc) begin
            r_bin_index     <= n_bin_index;
            r_prev_count    <= w_last ? '0 : r_in_count;
            r_rising        <= n_rising;
            r_started       <= n_started;
            r_failed        <= n_failed;
            r_peak_height   <= n_peak_height;
            r_peak_pos      <= n_peak_pos;
            r_valley_height <= n_valley_height;
            r_valley_pos    <= n_valley_pos;
            r_last_pos      <= n_last_pos;
            r_total         <= n_total;
        end
    end

    // queue write positions, results packed in order
    assign w_fin_ptr  = r_wr_ptr + PTR_BITS'(w_mid_v);
    assign w_done_ptr = w_fin_ptr + PTR_BITS'(w_fin_v);
    assign w_push_n   = w_proc ? (FILL_BITS'(w_mid_v) + FILL_BITS'(w_fin_v) +
                                  FILL_BITS'(w_last)) : '0;

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            if (w_mid_v) begin
                r_fifo[r_wr_ptr] <= w_mid;
            end
            if (w_fin_v) begin
                r_fifo[w_fin_ptr] <= w_fin;
            end
            if (w_last) begin
                r_fifo[w_done_ptr] <= w_done;
            end
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(w_push_n);
            r_rd_ptr <= r_rd_ptr + PTR_BITS'(w_pop);
            r_fill   <= r_fill + w_push_n - FILL_BITS'(w_pop);
        end
    end

    // output channel
    assign o_result.valid          = (r_fill != '0);
    assign o_result.extremum_index = r_fifo[r_rd_ptr].idx;
    assign o_result.result_kind    = r_fifo[r_rd_ptr].kind;
    assign o_result.extrema_found  = r_fifo[r_rd_ptr].total;
    assign o_result.end_of_run     = r_fifo[r_rd_ptr].last;

`ifndef SYNTHESIS
    // queue never overfills
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // a closing bin restarts the run at bin zero
    a_run_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_last) |=> (r_bin_index == '0 && !r_started && r_total == '0))
        else $error("run state not cleared after closing bin");

    // a failed run reports no extrema
    a_fail_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.result_kind == KIND_FAIL) |->
        (o_result.extrema_found == '0 && o_result.end_of_run))
        else $error("failure result carries extrema");
`endif

endmodule

[sim/tb.sv]
// tb: self-checking bench for histogram_peak_valley_finder, directed bins then random histograms
// depends on hpv_pkg, the channels in hpv_if and the top level; predicts every result in-bench
`timescale 1ns / 1ps

module tb;
    import hpv_pkg::*;

    // one directed bin, with a typed-in result where it is obvious
    typedef struct {
        logic [COUNT_BITS-1:0] cnt;
        logic                  fin;
        bit                    fixed;
        t_result               want;
    } t_bin_row;

    localparam t_result NO_WANT         = '0;
    localparam t_result EMPTY_RUN_DONE  = '{idx: '0, kind: KIND_OK,   total: '0, last: 1'b1};
    localparam t_result FAILED_RUN_DONE = '{idx: '0, kind: KIND_FAIL, total: '0, last: 1'b1};

    logic i_clk;
    logic i_rst_n;

    hpv_bin_if    bin_ch ();
    hpv_cfg_if    cfg_ch ();
    hpv_result_if res_ch ();

    histogram_peak_valley_finder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bin    (bin_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    // directed bins, threshold at its reset value of zero
    t_bin_row bin_script [19] = '{
        '{32'd0,          1'b0, 1'b0, NO_WANT},
        '{32'd0,          1'b0, 1'b0, NO_WANT},
        '{32'd0,          1'b1, 1'b1, EMPTY_RUN_DONE},
        '{32'hFFFF_FFFF,  1'b0, 1'b0, NO_WANT},
        '{32'd1,          1'b0, 1'b0, NO_WANT},
        '{32'd0,          1'b1, 1'b1, FAILED_RUN_DONE},
        '{32'd7,          1'b1, 1'b1, FAILED_RUN_DONE},
        '{32'd0,          1'b1, 1'b1, EMPTY_RUN_DONE},
        '{32'd0,          1'b0, 1'b0, NO_WANT},
        '{32'd0,          1'b0, 1'b0, NO_WANT},
        '{32'd5,          1'b0, 1'b0, NO_WANT},
        '{32'd9,          1'b0, 1'b0, NO_WANT},
        '{32'd9,          1'b0, 1'b0, NO_WANT},
        '{32'd2,          1'b0, 1'b0, NO_WANT},
        '{32'd8,          1'b0, 1'b0, NO_WANT},
        '{32'hFFFF_FFFF,  1'b0, 1'b0, NO_WANT},
        '{32'd0,          1'b0, 1'b0, NO_WANT},
        '{32'd3,          1'b0, 1'b0, NO_WANT},
        '{32'd1,          1'b1, 1'b0, NO_WANT}
    };

    // results still owed by the block, oldest first
    t_result extrema_due [$];

    // predicted block state
    logic [THR_BITS-1:0]   threshold_now;
    logic [IDX_BITS-1:0]   run_bin;
    logic [COUNT_BITS-1:0] prev_cnt;
    bit                    going_up;
    bit                    run_started;
    bit                    run_failed;
    logic [COUNT_BITS-1:0] peak_h;
    logic [IDX_BITS-1:0]   peak_pos;
    logic [COUNT_BITS-1:0] valley_h;
    logic [IDX_BITS-1:0]   valley_pos;
    logic [IDX_BITS-1:0]   last_pos;
    logic [TOTAL_BITS-1:0] run_total;

    int errors;
    int bins_sent;
    int send_idle_pct;
    int recv_idle_pct;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run state back to its start values
    function automatic void restart_run();
        run_bin     = '0;
        prev_cnt    = '0;
        going_up    = 1'b1;
        run_started = 1'b0;
        run_failed  = 1'b0;
        peak_h      = '0;
        peak_pos    = '0;
        valley_h    = '0;
        valley_pos  = '0;
        last_pos    = '0;
        run_total   = '0;
    endfunction

    function automatic void record_extremum(logic [IDX_BITS-1:0] pos, t_kind kind);
        t_result r;
        run_total = run_total + 1'b1;
        last_pos  = pos;
        r.idx     = pos;
        r.kind    = kind;
        r.total   = run_total;
        r.last    = 1'b0;
        extrema_due.push_back(r);
    endfunction

    function automatic void record_done(t_kind kind, logic [TOTAL_BITS-1:0] total);
        t_result r;
        r.idx   = '0;
        r.kind  = kind;
        r.total = total;
        r.last  = 1'b1;
        extrema_due.push_back(r);
    endfunction

    // a is above b by more than the threshold, no wrap-around
    function automatic bit clears_threshold(logic [COUNT_BITS-1:0] a, logic [COUNT_BITS-1:0] b);
        return (a > b) && ((a - b) > threshold_now);
    endfunction

    // advance the predicted state by one bin and queue what it yields
    function automatic void track_bin(logic [COUNT_BITS-1:0] cnt, logic fin);
        logic [IDX_BITS-1:0] i;
        bit                  closing;
        i       = run_bin;
        closing = fin || (run_bin >= IDX_BITS'(NUM_BINS - 1));
        if (i == 0) begin
            if (cnt > threshold_now) run_failed = 1'b1;
        end else if (!run_failed) begin
            // first valley is the bin right before the first non-zero bin past bin zero
            if (!run_started && cnt != 0) begin
                run_started = 1'b1;
                valley_pos  = i - 1'b1;
                record_extremum(i - 1'b1, KIND_VALLEY);
            end
            if (run_started) begin
                if (cnt > prev_cnt) going_up = 1'b1;
                else if (cnt < prev_cnt) going_up = 1'b0;
                if (going_up) begin
                    if (clears_threshold(cnt, valley_h)) begin
                        if (run_total > 1 && valley_pos > last_pos) begin
                            record_extremum(valley_pos, KIND_VALLEY);
                            peak_h = valley_h;
                        end
                        if (cnt > peak_h) begin
                            peak_h   = cnt;
                            peak_pos = i;
                        end
                    end
                end else begin
                    if (clears_threshold(peak_h, cnt)) begin
                        if (peak_pos > last_pos) begin
                            record_extremum(peak_pos, KIND_PEAK);
                            valley_h = peak_h;
                        end
                        if (cnt < valley_h) begin
                            valley_h   = cnt;
                            valley_pos = i;
                        end
                    end
                end
            end
        end
        prev_cnt = cnt;
        run_bin  = i + 1'b1;
        // close the run: pending valley, then the done result
        if (closing) begin
            if (run_failed) begin
                record_done(KIND_FAIL, '0);
            end else begin
                if (run_started && valley_pos > last_pos) record_extremum(valley_pos, KIND_VALLEY);
                record_done(KIND_OK, run_total);
            end
            restart_run();
        end
    endfunction

    // one bin transaction, entered and left at a falling edge
    task automatic send_bin(input logic [COUNT_BITS-1:0] cnt, input logic fin,
                            input bit fixed, input t_result want);
        int base;
        // each cycle idles with the sender's idle percentage
        while ($urandom_range(99) < send_idle_pct) begin
            bin_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        bin_ch.valid     <= 1'b1;
        bin_ch.bin_count <= cnt;
        bin_ch.final_bin <= fin;
        do @(posedge i_clk); while (!bin_ch.ready);
        base = extrema_due.size();
        track_bin(cnt, fin);
        if (fixed) begin
            while (extrema_due.size() > base) void'(extrema_due.pop_back());
            extrema_due.push_back(want);
        end
        bins_sent++;
        @(negedge i_clk);
    endtask

    // threshold write, only once the block has drained
    task automatic load_threshold(input logic [THR_BITS-1:0] value);
        while (extrema_due.size() != 0) @(negedge i_clk);
        // bins that yield nothing may still sit in the pipeline
        repeat (8) @(negedge i_clk);
        cfg_ch.valid                <= 1'b1;
        cfg_ch.hysteresis_threshold <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        threshold_now = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // next bin count, steps sized around the threshold
    function automatic logic [COUNT_BITS-1:0] next_count(logic [COUNT_BITS-1:0] prev,
                                                         logic [THR_BITS-1:0] thr);
        longint unsigned span;
        longint unsigned d;
        longint unsigned v;
        int              pick;
        pick = $urandom_range(15);
        span = {32'd0, thr} * 2 + 4;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        d = $urandom_range(span[31:0], 0);
        if (pick == 0) return $urandom;
        if (pick == 1) return '0;
        if (pick == 2) return prev;
        if (pick < 9) begin
            v = {32'd0, prev} + d;
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        end else begin
            v = (d > prev) ? 64'd0 : {32'd0, prev} - d;
        end
        return v[COUNT_BITS-1:0];
    endfunction

    // one histogram: mostly leading zeros then a random walk, sometimes a bad bin zero
    task automatic send_histogram(input logic [THR_BITS-1:0] thr, input bit full_length);
        int                    len;
        int                    lead;
        logic [COUNT_BITS-1:0] c;
        logic                  fin;
        len  = full_length ? NUM_BINS : $urandom_range(24, 1);
        lead = $urandom_range(3, 0);
        c    = '0;
        for (int k = 0; k < len; k++) begin
            if (k == 0) c = ($urandom_range(9) == 0) ? $urandom : '0;
            else if (k <= lead) c = '0;
            else c = next_count(c, thr);
            if (k == len - 1) fin = full_length ? 1'($urandom_range(1)) : 1'b1;
            else fin = 1'b0;
            send_bin(c, fin, 1'b0, NO_WANT);
        end
    endtask

    // result side: random stall
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result side: compare against the oldest owed result
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.idx   = res_ch.extremum_index;
            got.kind  = t_kind'(res_ch.result_kind);
            got.total = res_ch.extrema_found;
            got.last  = res_ch.end_of_run;
            if (extrema_due.size() == 0) begin
                errors++;
                // keep the log readable on a badly broken block
                if (errors <= 200)
                    $display("%0t: unexpected result idx %0d kind %0d count %0d end %0b",
                             $time, got.idx, got.kind, got.total, got.last);
            end else begin
                want = extrema_due.pop_front();
                if (got.idx !== want.idx || got.kind !== want.kind ||
                    got.total !== want.total || got.last !== want.last) begin
                    errors++;
                    if (errors <= 200)
                        $display({"%0t: result mismatch, expected idx %0d kind %0d count %0d",
                                  " end %0b, actual idx %0d kind %0d count %0d end %0b"},
                                 $time, want.idx, want.kind, want.total, want.last,
                                 got.idx, got.kind, got.total, got.last);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        errors        = 0;
        bins_sent     = 0;
        send_idle_pct = 24;
        recv_idle_pct = 46;
        threshold_now = '0;
        restart_run();
        i_rst_n                     = 1'b0;
        bin_ch.valid                = 1'b0;
        bin_ch.bin_count            = '0;
        bin_ch.final_bin            = 1'b0;
        cfg_ch.valid                = 1'b0;
        cfg_ch.hysteresis_threshold = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed bins
        foreach (bin_script[r])
            send_bin(bin_script[r].cnt, bin_script[r].fin, bin_script[r].fixed,
                     bin_script[r].want);
        bin_ch.valid <= 1'b0;

        // top threshold: nothing beyond the first valley can commit
        load_threshold(32'hFFFF_FFFF);
        while (bins_sent < 60) send_histogram(threshold_now, 1'b0);
        bin_ch.valid <= 1'b0;

        // small threshold, sender now stalls more than the receiver
        send_idle_pct = 46;
        recv_idle_pct = 24;
        load_threshold($urandom_range(64, 1));
        while (bins_sent < 120) send_histogram(threshold_now, 1'b0);
        bin_ch.valid <= 1'b0;

        // zero threshold, full-length histogram closed by the bin count, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_threshold('0);
        send_histogram(threshold_now, 1'b1);
        bin_ch.valid <= 1'b0;

        // large threshold with full-range counts
        load_threshold($urandom_range(32'h7FFF_FFFF, 32'h1000_0000));
        while (bins_sent < 420) send_histogram(threshold_now, 1'b0);
        bin_ch.valid <= 1'b0;

        while (extrema_due.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/hpv_pkg.sv
rtl/core/hpv_if.sv
rtl/core/histogram_peak_valley_finder.sv
sim/tb.sv
